### rtl/core/tlma_pkg.sv
// ----------------------------------------------------------------------------
// Torus linear map address package
// Shared widths, reset values and register indexes of the address generator.
// ----------------------------------------------------------------------------
`default_nettype none

package tlma_pkg;

    // Defaults of the top level parameters.
    localparam int COORD_BITS_DEF  = 12;
    localparam int FRAC_BITS_DEF   = 24;
    localparam int MAX_REPEATS_DEF = 15;

    // Matrix entries are signed Q8.24.
    localparam int MAT_BITS = 32;
    localparam int MAT_FRAC = 24;

    localparam int REP_BITS      = 4;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [MAT_BITS-1:0] MAT_ONE   = 32'h0100_0000;
    localparam logic [MAT_BITS-1:0] MAT_ZERO  = 32'h0000_0000;
    localparam logic [REP_BITS-1:0] REP_RESET = 4'd1;

    typedef logic signed [MAT_BITS-1:0] t_mat;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_MATRIX_A     = 3'd0,
        CFG_MATRIX_B     = 3'd1,
        CFG_MATRIX_C     = 3'd2,
        CFG_MATRIX_D     = 3'd3,
        CFG_REPEAT_COUNT = 3'd4,
        CFG_IMAGE_WIDTH  = 3'd5,
        CFG_IMAGE_HEIGHT = 3'd6
    } t_cfg_reg;

endpackage

`default_nettype wire

### rtl/core/torus_linear_map_address.sv
// ----------------------------------------------------------------------------
// Torus linear map address generator
// Maps a destination pixel to the source pixel of a 2x2 linear map on the
// unit torus, applied a configured number of times.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: a coordinate pair is taken at each rising edge where start
//   is high and busy is low. busy is only high during reset and until r_live
//   is set once reset ends, so one pair can be taken in every cycle.
//   Result channel: o_valid marks each result for exactly one cycle; results
//   come out in input order, one per input pair.
//   Configuration: registers are written over the cfg channel (index, data, valid/ready),
//   by the user only while no coordinate is in flight; the block does not enforce it.
//   A result takes the same path whatever the repeat count: the normalizing
//   divider takes one quotient bit per stage and every matrix product has a
//   multiply stage and an add stage, bypassed when its index is not below the
//   count, followed by the scale register and the output register.
//   Throughput is one pair per cycle while busy is low.
//   Reset clears all valid bits and loads the identity matrix, a repeat count
//   of one and a 4096 by 4096 image. The receiver cannot stall, so the
//   pipeline never holds.
// ----------------------------------------------------------------------------
`default_nettype none

module torus_linear_map_address #(
    parameter int COORD_BITS  = tlma_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS   = tlma_pkg::FRAC_BITS_DEF,
    parameter int MAX_REPEATS = tlma_pkg::MAX_REPEATS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [COORD_BITS-1:0]              i_dest_x,
    input  wire logic [COORD_BITS-1:0]              i_dest_y,
    output logic                                    o_valid,
    output logic [COORD_BITS-1:0]                   o_source_x,
    output logic [COORD_BITS-1:0]                   o_source_y,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [tlma_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [tlma_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);

    localparam int SW         = COORD_BITS + 1;
    localparam int DIV_STAGES = COORD_BITS + FRAC_BITS;
    localparam int PW         = tlma_pkg::MAT_FRAC + FRAC_BITS;
    localparam int FW         = tlma_pkg::MAT_BITS + FRAC_BITS + 1;
    localparam int CNT_W      = ($clog2(MAX_REPEATS + 1) > tlma_pkg::REP_BITS) ?
                                $clog2(MAX_REPEATS + 1) : tlma_pkg::REP_BITS;
    localparam int LATENCY    = DIV_STAGES + 2 * MAX_REPEATS + 2;
    localparam logic [SW-1:0] SIZE_FULL = {1'b1, {COORD_BITS{1'b0}}};

    // ------------------------------------------------------------------
    // Configuration registers and control
    // ------------------------------------------------------------------
    logic                          r_live;
    tlma_pkg::t_mat                r_cfg_mat [4];
    logic [tlma_pkg::REP_BITS-1:0] r_cfg_rep;
    logic [SW-1:0]                 r_cfg_size [2];
    logic                          w_accept;
    logic [CNT_W-1:0]              rep_eff;

    assign busy        = ~r_live;
    assign o_cfg_ready = r_live;
    assign w_accept    = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live        <= 1'b0;
            r_cfg_mat[0]  <= tlma_pkg::MAT_ONE;
            r_cfg_mat[1]  <= tlma_pkg::MAT_ZERO;
            r_cfg_mat[2]  <= tlma_pkg::MAT_ZERO;
            r_cfg_mat[3]  <= tlma_pkg::MAT_ONE;
            r_cfg_rep     <= tlma_pkg::REP_RESET;
            r_cfg_size[0] <= SIZE_FULL;
            r_cfg_size[1] <= SIZE_FULL;
        end else begin
            r_live <= 1'b1;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    tlma_pkg::CFG_MATRIX_A:     r_cfg_mat[0]  <= i_cfg_data;
                    tlma_pkg::CFG_MATRIX_B:     r_cfg_mat[1]  <= i_cfg_data;
                    tlma_pkg::CFG_MATRIX_C:     r_cfg_mat[2]  <= i_cfg_data;
                    tlma_pkg::CFG_MATRIX_D:     r_cfg_mat[3]  <= i_cfg_data;
                    tlma_pkg::CFG_REPEAT_COUNT: r_cfg_rep     <= i_cfg_data[tlma_pkg::REP_BITS-1:0];
                    tlma_pkg::CFG_IMAGE_WIDTH:  r_cfg_size[0] <= i_cfg_data[SW-1:0];
                    tlma_pkg::CFG_IMAGE_HEIGHT: r_cfg_size[1] <= i_cfg_data[SW-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Counts above the number of product stages saturate.
    always_comb begin
        if (CNT_W'(r_cfg_rep) > CNT_W'(MAX_REPEATS)) begin
            rep_eff = CNT_W'(MAX_REPEATS);
        end else begin
            rep_eff = CNT_W'(r_cfg_rep);
        end
    end

    // ------------------------------------------------------------------
    // Normalizing divider: (coord << FRAC_BITS) / size, one quotient bit
    // per stage. Only the low FRAC_BITS quotient bits are kept, which is
    // the reduction modulo one.
    // ------------------------------------------------------------------
    logic                  r_dv_vld [1:DIV_STAGES];
    logic [SW-1:0]         r_dv_rem [1:DIV_STAGES][2];
    logic [COORD_BITS-1:0] r_dv_num [1:DIV_STAGES][2];
    logic [FRAC_BITS-1:0]  r_dv_quo [1:DIV_STAGES][2];
    logic [FRAC_BITS-1:0]  dv_frac  [2];

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
        logic                  src_vld;
        logic [SW-1:0]         src_rem [2];
        logic [COORD_BITS-1:0] src_num [2];
        logic [FRAC_BITS-1:0]  src_quo [2];

        if (s == 0) begin : g_head
            assign src_vld    = w_accept;
            assign src_rem[0] = '0;
            assign src_rem[1] = '0;
            assign src_num[0] = i_dest_x;
            assign src_num[1] = i_dest_y;
            assign src_quo[0] = '0;
            assign src_quo[1] = '0;
        end else begin : g_body
            assign src_vld    = r_dv_vld[s];
            assign src_rem[0] = r_dv_rem[s][0];
            assign src_rem[1] = r_dv_rem[s][1];
            assign src_num[0] = r_dv_num[s][0];
            assign src_num[1] = r_dv_num[s][1];
            assign src_quo[0] = r_dv_quo[s][0];
            assign src_quo[1] = r_dv_quo[s][1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[s+1] <= 1'b0;
            end else begin
                r_dv_vld[s+1] <= src_vld;
            end
        end

        for (genvar a = 0; a < 2; a++) begin : g_axis
            logic [SW:0] trial;
            logic [SW:0] diff;
            logic        take;

            assign trial = {src_rem[a], src_num[a][COORD_BITS-1]};
            assign diff  = trial - {1'b0, r_cfg_size[a]};
            assign take  = (trial >= {1'b0, r_cfg_size[a]});

            always_ff @(posedge i_clk) begin
                r_dv_rem[s+1][a] <= take ? diff[SW-1:0] : trial[SW-1:0];
                r_dv_num[s+1][a] <= {src_num[a][COORD_BITS-2:0], 1'b0};
                r_dv_quo[s+1][a] <= {src_quo[a][FRAC_BITS-2:0], take};
            end
        end
    end

    // A zero size would give an all-ones quotient; that axis is taken as zero.
    assign dv_frac[0] = (r_cfg_size[0] == '0) ? '0 : r_dv_quo[DIV_STAGES][0];
    assign dv_frac[1] = (r_cfg_size[1] == '0) ? '0 : r_dv_quo[DIV_STAGES][1];

    // ------------------------------------------------------------------
    // Matrix product chain: per step a multiply stage and an add stage.
    // Products are kept modulo 2^PW, which is exact for the wrap to [0,1).
    // ------------------------------------------------------------------
    logic                 r_rm_vld  [MAX_REPEATS];
    logic [PW-1:0]        r_rm_prod [MAX_REPEATS][4];
    logic [FRAC_BITS-1:0] r_rm_p    [MAX_REPEATS][2];
    logic                 r_rs_vld  [MAX_REPEATS];
    logic [FRAC_BITS-1:0] r_rs_p    [MAX_REPEATS][2];
    logic                 rep_en    [MAX_REPEATS];

    for (genvar k = 0; k < MAX_REPEATS; k++) begin : g_rep
        logic                 src_vld;
        logic [FRAC_BITS-1:0] src_p [2];
        logic signed [FW-1:0] full  [4];
        logic [PW-1:0]        sum   [2];

        if (k == 0) begin : g_head
            assign src_vld  = r_dv_vld[DIV_STAGES];
            assign src_p[0] = dv_frac[0];
            assign src_p[1] = dv_frac[1];
        end else begin : g_body
            assign src_vld  = r_rs_vld[k-1];
            assign src_p[0] = r_rs_p[k-1][0];
            assign src_p[1] = r_rs_p[k-1][1];
        end

        assign rep_en[k] = (CNT_W'(k) < rep_eff);

        // Entries a and c multiply x, entries b and d multiply y.
        for (genvar j = 0; j < 4; j++) begin : g_mul
            assign full[j] = r_cfg_mat[j] * $signed({1'b0, src_p[j % 2]});
        end

        assign sum[0] = r_rm_prod[k][0] + r_rm_prod[k][1];
        assign sum[1] = r_rm_prod[k][2] + r_rm_prod[k][3];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_rm_vld[k] <= 1'b0;
                r_rs_vld[k] <= 1'b0;
            end else begin
                r_rm_vld[k] <= src_vld;
                r_rs_vld[k] <= r_rm_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rm_prod[k][0] <= full[0][PW-1:0];
            r_rm_prod[k][1] <= full[1][PW-1:0];
            r_rm_prod[k][2] <= full[2][PW-1:0];
            r_rm_prod[k][3] <= full[3][PW-1:0];
            r_rm_p[k][0]    <= src_p[0];
            r_rm_p[k][1]    <= src_p[1];
            // Dropping the low fraction bits floors toward minus infinity.
            r_rs_p[k][0]    <= rep_en[k] ? sum[0][tlma_pkg::MAT_FRAC +: FRAC_BITS]
                                         : r_rm_p[k][0];
            r_rs_p[k][1]    <= rep_en[k] ? sum[1][tlma_pkg::MAT_FRAC +: FRAC_BITS]
                                         : r_rm_p[k][1];
        end
    end

    // ------------------------------------------------------------------
    // Scale back to pixels and output register
    // ------------------------------------------------------------------
    logic                       r_sc_vld;
    logic [FRAC_BITS+SW-1:0]    r_sc_prod [2];
    logic                       r_out_vld;
    logic [COORD_BITS-1:0]      r_out_x;
    logic [COORD_BITS-1:0]      r_out_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sc_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_sc_vld  <= r_rs_vld[MAX_REPEATS-1];
            r_out_vld <= r_sc_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sc_prod[0] <= r_rs_p[MAX_REPEATS-1][0] * r_cfg_size[0];
        r_sc_prod[1] <= r_rs_p[MAX_REPEATS-1][1] * r_cfg_size[1];
        r_out_x      <= r_sc_prod[0][FRAC_BITS +: COORD_BITS];
        r_out_y      <= r_sc_prod[1][FRAC_BITS +: COORD_BITS];
    end

    assign o_valid    = r_out_vld;
    assign o_source_x = r_out_x;
    assign o_source_y = r_out_y;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // Every result traces back to a matching earlier input transfer.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_accept, LATENCY))
        else $error("result without a matching input transfer");

    // A product stage past the repeat count leaves the fraction untouched.
    a_bypass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rs_vld[MAX_REPEATS-1] && $past(!rep_en[MAX_REPEATS-1]) |->
            (r_rs_p[MAX_REPEATS-1][0] == $past(r_rm_p[MAX_REPEATS-1][0])) &&
            (r_rs_p[MAX_REPEATS-1][1] == $past(r_rm_p[MAX_REPEATS-1][1])))
        else $error("disabled product stage changed the fraction");

    // A fraction below one scales to a column below the width.
    a_range_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && ($past(r_cfg_size[0], 2) != '0) &&
            ($past(r_cfg_size[0], 2) <= SIZE_FULL) |->
            ({1'b0, o_source_x} < $past(r_cfg_size[0], 2)))
        else $error("source column not below image width");

    a_range_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && ($past(r_cfg_size[1], 2) != '0) &&
            ($past(r_cfg_size[1], 2) <= SIZE_FULL) |->
            ({1'b0, o_source_y} < $past(r_cfg_size[1], 2)))
        else $error("source row not below image height");

endmodule

`default_nettype wire
